// ----- rtl/lcdseq_pkg.sv -----
`default_nettype none
package lcdseq_pkg;

    localparam int WAIT_BITS_DEF = 16;

    localparam logic [7:0]  FN_SET_RST      = 8'h28;
    localparam logic [7:0]  DISP_CTL_RST    = 8'h0D;
    localparam logic [7:0]  ENTRY_MODE_RST  = 8'h06;
    localparam logic [9:0]  SHORT_WAIT_RST  = 10'd40;
    localparam logic [15:0] LONG_WAIT_RST   = 16'd2000;
    localparam logic [15:0] POWERUP_WAIT_RST = 16'd55000;

    localparam logic [15:0] WAKE_GAP_US      = 16'd1000;
    localparam logic [7:0]  CURSOR_SHIFT_CMD = 8'h10;
    localparam logic [7:0]  LONG_CMD_MAX     = 8'h03;
    localparam logic [3:0]  WAKE_NIB         = 4'h3;
    localparam logic [3:0]  BUS4_NIB         = 4'h2;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FN_SET     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DISP_CTL   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ENTRY_MODE = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_WAIT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_WAIT  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PWR_WAIT   = 3'd5;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_INIT  = 1'b1;

    typedef logic [3:0] t_step;
    localparam t_step STEP_WR_HI    = 4'd0;
    localparam t_step STEP_WR_LO    = 4'd1;
    localparam t_step STEP_WAKE0    = 4'd2;
    localparam t_step STEP_WAKE1    = 4'd3;
    localparam t_step STEP_WAKE2    = 4'd4;
    localparam t_step STEP_BUS4     = 4'd5;
    localparam t_step STEP_FN_HI    = 4'd6;
    localparam t_step STEP_FN_LO    = 4'd7;
    localparam t_step STEP_SHIFT_HI = 4'd8;
    localparam t_step STEP_SHIFT_LO = 4'd9;
    localparam t_step STEP_DISP_HI  = 4'd10;
    localparam t_step STEP_DISP_LO  = 4'd11;
    localparam t_step STEP_ENTRY_HI = 4'd12;
    localparam t_step STEP_ENTRY_LO = 4'd13;

    typedef enum logic [1:0] {NIB_CONST, NIB_HI, NIB_LO} t_nib_src;
    typedef enum logic [2:0] {BYTE_REQ, BYTE_FN, BYTE_SHIFT, BYTE_DISP, BYTE_ENTRY} t_byte_src;
    typedef enum logic [2:0] {
        WAIT_PENDING, WAIT_POWERUP, WAIT_GAP, WAIT_SHORT, WAIT_ZERO
    } t_wait_src;
    typedef enum logic [1:0] {PEND_KEEP, PEND_SHORT, PEND_BYTE} t_pend_op;
    typedef enum logic {SEQ_NEXT, SEQ_END} t_seq_op;

    typedef struct packed {
        t_nib_src  nib_src;
        logic [3:0] nib;
        t_byte_src byte_src;
        t_wait_src wait_src;
        t_pend_op  pend_op;
        logic      rs_req;
        logic      last;
        t_seq_op   seq;
    } t_ucode;

    typedef struct packed {
        logic   load;
        logic   emit;
        t_ucode uc;
    } t_dp_ctl;

    function automatic t_ucode mk_uc(t_nib_src ns, logic [3:0] nib, t_byte_src bs,
                                     t_wait_src ws, t_pend_op po, logic rs_req,
                                     logic last, t_seq_op seq);
        t_ucode u;
        u.nib_src  = ns;
        u.nib      = nib;
        u.byte_src = bs;
        u.wait_src = ws;
        u.pend_op  = po;
        u.rs_req   = rs_req;
        u.last     = last;
        u.seq      = seq;
        return u;
    endfunction

    function automatic t_ucode ucode_rom(t_step s);
        t_ucode u;
        unique case (s) inside
            STEP_WR_HI:    u = mk_uc(NIB_HI, 4'h0, BYTE_REQ, WAIT_PENDING, PEND_KEEP,
                                     1'b1, 1'b0, SEQ_NEXT);
            STEP_WR_LO:    u = mk_uc(NIB_LO, 4'h0, BYTE_REQ, WAIT_ZERO, PEND_BYTE,
                                     1'b1, 1'b1, SEQ_END);
            STEP_WAKE0:    u = mk_uc(NIB_CONST, WAKE_NIB, BYTE_REQ, WAIT_POWERUP, PEND_KEEP,
                                     1'b0, 1'b0, SEQ_NEXT);
            STEP_WAKE1,
            STEP_WAKE2:    u = mk_uc(NIB_CONST, WAKE_NIB, BYTE_REQ, WAIT_GAP, PEND_KEEP,
                                     1'b0, 1'b0, SEQ_NEXT);
            STEP_BUS4:     u = mk_uc(NIB_CONST, BUS4_NIB, BYTE_REQ, WAIT_SHORT, PEND_SHORT,
                                     1'b0, 1'b0, SEQ_NEXT);
            STEP_FN_HI:    u = mk_uc(NIB_HI, 4'h0, BYTE_FN, WAIT_PENDING, PEND_KEEP,
                                     1'b0, 1'b0, SEQ_NEXT);
            STEP_FN_LO:    u = mk_uc(NIB_LO, 4'h0, BYTE_FN, WAIT_ZERO, PEND_BYTE,
                                     1'b0, 1'b0, SEQ_NEXT);
            STEP_SHIFT_HI: u = mk_uc(NIB_HI, 4'h0, BYTE_SHIFT, WAIT_PENDING, PEND_KEEP,
                                     1'b0, 1'b0, SEQ_NEXT);
            STEP_SHIFT_LO: u = mk_uc(NIB_LO, 4'h0, BYTE_SHIFT, WAIT_ZERO, PEND_BYTE,
                                     1'b0, 1'b0, SEQ_NEXT);
            STEP_DISP_HI:  u = mk_uc(NIB_HI, 4'h0, BYTE_DISP, WAIT_PENDING, PEND_KEEP,
                                     1'b0, 1'b0, SEQ_NEXT);
            STEP_DISP_LO:  u = mk_uc(NIB_LO, 4'h0, BYTE_DISP, WAIT_ZERO, PEND_BYTE,
                                     1'b0, 1'b0, SEQ_NEXT);
            STEP_ENTRY_HI: u = mk_uc(NIB_HI, 4'h0, BYTE_ENTRY, WAIT_PENDING, PEND_KEEP,
                                     1'b0, 1'b0, SEQ_NEXT);
            STEP_ENTRY_LO: u = mk_uc(NIB_LO, 4'h0, BYTE_ENTRY, WAIT_ZERO, PEND_BYTE,
                                     1'b0, 1'b1, SEQ_END);
            default:       u = mk_uc(NIB_CONST, 4'h0, BYTE_REQ, WAIT_ZERO, PEND_KEEP,
                                     1'b0, 1'b1, SEQ_END);
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/lcdseq_if.sv -----
`default_nettype none
interface lcdseq_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] byte_value;
    logic       is_data;

    modport source (output valid, req_type, byte_value, is_data, input ready);
    modport sink   (input valid, req_type, byte_value, is_data, output ready);
endinterface

interface lcdseq_evt_if;
    logic        valid;
    logic        ready;
    logic [3:0]  nibble;
    logic        reg_select;
    logic [15:0] wait_before_us;
    logic        last;

    modport source (output valid, nibble, reg_select, wait_before_us, last, input ready);
    modport sink   (input valid, nibble, reg_select, wait_before_us, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/lcd_nibble_command_sequencer.sv -----
`default_nettype none
// Channel   Dir  Payload                                        Beat when
// i_req     in   req_type, byte_value, is_data                  valid & ready
// o_evt     out  nibble, reg_select, wait_before_us, last       valid & ready
// i_cfg_*   in   register index, write data                     i_cfg_we
//
// A control program steps through one strobe beat per cycle unless the output
// stalls: 2 beats for a byte write, 12 for init. A new request is taken in the
// cycle of the final beat. Output stalls hold the step counter. Synchronous
// reset restores register defaults and clears the pending settle time.
module lcd_nibble_command_sequencer
    import lcdseq_pkg::*;
#(
    parameter int WAIT_BITS = WAIT_BITS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    lcdseq_req_if.sink               i_req,
    lcdseq_evt_if.source             o_evt,
    input  wire                      i_cfg_we,
    input  wire [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_BITS-1:0]  i_cfg_data
);

    t_dp_ctl ctl;
    logic    out_valid;
    logic    req_ready;

    lcdseq_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .i_out_valid (out_valid),
        .i_out_ready (o_evt.ready),
        .o_req_ready (req_ready),
        .o_ctl       (ctl)
    );

    lcdseq_datapath #(
        .WAIT_BITS (WAIT_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .i_byte_value     (i_req.byte_value),
        .i_is_data        (i_req.is_data),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (o_evt.ready),
        .o_out_valid      (out_valid),
        .o_nibble         (o_evt.nibble),
        .o_reg_select     (o_evt.reg_select),
        .o_wait_before_us (o_evt.wait_before_us),
        .o_last           (o_evt.last)
    );

    assign i_req.ready = req_ready;
    assign o_evt.valid = out_valid;

endmodule
`default_nettype wire

// ----- rtl/lcdseq_sequencer.sv -----
`default_nettype none
module lcdseq_sequencer
    import lcdseq_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_req_valid,
    input  wire     i_req_type,
    input  wire     i_out_valid,
    input  wire     i_out_ready,
    output logic    o_req_ready,
    output t_dp_ctl o_ctl
);

    logic   r_busy, n_busy;
    t_step  r_step, n_step;
    t_ucode uc;
    logic   out_free, emit, finish, accept;

    always_comb begin
        uc       = ucode_rom(r_step);
        out_free = !i_out_valid || i_out_ready;
        emit     = r_busy && out_free;
        finish   = emit && (uc.seq == SEQ_END);
        o_req_ready = !r_busy || finish;
        accept   = i_req_valid && o_req_ready;
    end

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (accept) begin
            n_busy = 1'b1;
            n_step = (i_req_type == REQ_INIT) ? STEP_WAKE0 : STEP_WR_HI;
        end else if (finish) begin
            n_busy = 1'b0;
        end else if (emit) begin
            n_step = r_step + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_WR_HI;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    assign o_ctl.load = accept;
    assign o_ctl.emit = emit;
    assign o_ctl.uc   = uc;

endmodule
`default_nettype wire

// ----- rtl/lcdseq_datapath.sv -----
`default_nettype none
module lcdseq_datapath
    import lcdseq_pkg::*;
#(
    parameter int WAIT_BITS = WAIT_BITS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  t_dp_ctl                  i_ctl,
    input  wire [7:0]                i_byte_value,
    input  wire                      i_is_data,
    input  wire                      i_cfg_we,
    input  wire [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  wire                      i_out_ready,
    output logic                     o_out_valid,
    output logic [3:0]               o_nibble,
    output logic                     o_reg_select,
    output logic [15:0]              o_wait_before_us,
    output logic                     o_last
);

    logic [7:0]  r_fn_set, r_disp_ctl, r_entry_mode;
    logic [9:0]  r_short_wait;
    logic [15:0] r_long_wait, r_pwr_wait;

    logic [7:0]           r_byte;
    logic                 r_is_data;
    logic [WAIT_BITS-1:0] r_pend, n_pend;

    logic        r_ov;
    logic [3:0]  r_nib;
    logic        r_rs;
    logic [15:0] r_wait;
    logic        r_last;

    logic [7:0]           sel_byte;
    logic [3:0]           nib;
    logic [31:0]          pwr32, gap32, short32, long32, wsel32;
    logic [WAIT_BITS-1:0] wsel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fn_set     <= FN_SET_RST;
            r_disp_ctl   <= DISP_CTL_RST;
            r_entry_mode <= ENTRY_MODE_RST;
            r_short_wait <= SHORT_WAIT_RST;
            r_long_wait  <= LONG_WAIT_RST;
            r_pwr_wait   <= POWERUP_WAIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FN_SET:     r_fn_set     <= i_cfg_data[7:0];
                CFG_DISP_CTL:   r_disp_ctl   <= i_cfg_data[7:0];
                CFG_ENTRY_MODE: r_entry_mode <= i_cfg_data[7:0];
                CFG_SHORT_WAIT: r_short_wait <= i_cfg_data[9:0];
                CFG_LONG_WAIT:  r_long_wait  <= i_cfg_data[15:0];
                CFG_PWR_WAIT:   r_pwr_wait   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        pwr32   = 32'(r_pwr_wait);
        gap32   = 32'(WAKE_GAP_US);
        short32 = 32'(r_short_wait);
        long32  = 32'(r_long_wait);

        case (i_ctl.uc.byte_src)
            BYTE_FN:    sel_byte = r_fn_set;
            BYTE_SHIFT: sel_byte = CURSOR_SHIFT_CMD;
            BYTE_DISP:  sel_byte = r_disp_ctl;
            BYTE_ENTRY: sel_byte = r_entry_mode;
            default:    sel_byte = r_byte;
        endcase

        case (i_ctl.uc.nib_src)
            NIB_HI:  nib = sel_byte[7:4];
            NIB_LO:  nib = sel_byte[3:0];
            default: nib = i_ctl.uc.nib;
        endcase

        case (i_ctl.uc.wait_src)
            WAIT_PENDING: wsel = r_pend;
            WAIT_POWERUP: wsel = pwr32[WAIT_BITS-1:0];
            WAIT_GAP:     wsel = gap32[WAIT_BITS-1:0];
            WAIT_SHORT:   wsel = short32[WAIT_BITS-1:0];
            default:      wsel = '0;
        endcase
        wsel32 = 32'(wsel);

        n_pend = r_pend;
        case (i_ctl.uc.pend_op)
            PEND_SHORT: n_pend = short32[WAIT_BITS-1:0];
            PEND_BYTE:  n_pend = (sel_byte <= LONG_CMD_MAX) ? long32[WAIT_BITS-1:0]
                                                            : short32[WAIT_BITS-1:0];
            default:    n_pend = r_pend;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_byte    <= i_byte_value;
            r_is_data <= i_is_data;
        end
        if (i_ctl.emit) begin
            r_nib  <= nib;
            r_rs   <= i_ctl.uc.rs_req & r_is_data;
            r_wait <= (|wsel32[31:16]) ? 16'hFFFF : wsel32[15:0];
            r_last <= i_ctl.uc.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_pend <= '0;
        end else begin
            if (i_ctl.emit) begin
                r_ov   <= 1'b1;
                r_pend <= n_pend;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_ov;
    assign o_nibble         = r_nib;
    assign o_reg_select     = r_rs;
    assign o_wait_before_us = r_wait;
    assign o_last           = r_last;

endmodule
`default_nettype wire

// ----- rtl/lcdseq_checker.sv -----
`default_nettype none
module lcdseq_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_req_valid,
    input wire        i_req_ready,
    input wire        i_evt_valid,
    input wire        i_evt_ready,
    input wire [3:0]  i_evt_nibble,
    input wire        i_evt_rs,
    input wire [15:0] i_evt_wait,
    input wire        i_evt_last
);

    a_evt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt_valid && !i_evt_ready |=> i_evt_valid && $stable(i_evt_nibble)
            && $stable(i_evt_rs) && $stable(i_evt_wait) && $stable(i_evt_last))
        else $error("stalled output beat changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while previous one not started");

    a_last_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt_valid && i_evt_last |-> i_evt_wait == 16'd0)
        else $error("final beat carries a nonzero wait");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_evt_valid)
        else $error("output beat right after reset");

endmodule

bind lcd_nibble_command_sequencer lcdseq_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_evt_valid (o_evt.valid),
    .i_evt_ready (o_evt.ready),
    .i_evt_nibble(o_evt.nibble),
    .i_evt_rs    (o_evt.reg_select),
    .i_evt_wait  (o_evt.wait_before_us),
    .i_evt_last  (o_evt.last)
);
`default_nettype wire

// ----- sim/tb_lcd_nibble_command_sequencer.sv -----
`timescale 1ns / 1ps
module tb_lcd_nibble_command_sequencer;
    import lcdseq_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 410;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 200;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [3:0]  nib;
        logic        rs;
        logic [15:0] wait_us;
        logic        last;
    } t_strobe;

    typedef struct packed {
        logic       rt;
        logic [7:0] byt;
        logic       dat;
        logic       typed;
        t_strobe    hi;
        t_strobe    lo;
    } t_dir_row;

    localparam int N_DIR = 17;
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{REQ_WRITE, 8'h00, 1'b0, 1'b1, '{4'h0, 1'b0, 16'd0, 1'b0},
                                        '{4'h0, 1'b0, 16'd0, 1'b1}},
        '{REQ_WRITE, 8'hFF, 1'b1, 1'b1, '{4'hF, 1'b1, 16'd2000, 1'b0},
                                        '{4'hF, 1'b1, 16'd0, 1'b1}},
        '{REQ_WRITE, 8'h03, 1'b0, 1'b1, '{4'h0, 1'b0, 16'd40, 1'b0},
                                        '{4'h3, 1'b0, 16'd0, 1'b1}},
        '{REQ_WRITE, 8'h04, 1'b1, 1'b1, '{4'h0, 1'b1, 16'd2000, 1'b0},
                                        '{4'h4, 1'b1, 16'd0, 1'b1}},
        '{REQ_INIT,  8'h00, 1'b0, 1'b0, '0, '0},
        '{REQ_WRITE, 8'h01, 1'b1, 1'b1, '{4'h0, 1'b1, 16'd40, 1'b0},
                                        '{4'h1, 1'b1, 16'd0, 1'b1}},
        '{REQ_WRITE, 8'h02, 1'b0, 1'b1, '{4'h0, 1'b0, 16'd2000, 1'b0},
                                        '{4'h2, 1'b0, 16'd0, 1'b1}},
        '{REQ_WRITE, 8'h80, 1'b0, 1'b1, '{4'h8, 1'b0, 16'd2000, 1'b0},
                                        '{4'h0, 1'b0, 16'd0, 1'b1}},
        '{REQ_WRITE, 8'h7F, 1'b1, 1'b0, '0, '0},
        '{REQ_WRITE, 8'h10, 1'b0, 1'b0, '0, '0},
        '{REQ_WRITE, 8'h5A, 1'b1, 1'b0, '0, '0},
        '{REQ_WRITE, 8'hA5, 1'b0, 1'b0, '0, '0},
        '{REQ_INIT,  8'hFF, 1'b1, 1'b0, '0, '0},
        '{REQ_INIT,  8'h00, 1'b0, 1'b0, '0, '0},
        '{REQ_WRITE, 8'h03, 1'b1, 1'b0, '0, '0},
        '{REQ_WRITE, 8'hFC, 1'b0, 1'b0, '0, '0},
        '{REQ_WRITE, 8'h00, 1'b1, 1'b0, '0, '0}
    };

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    lcdseq_req_if req_ch ();
    lcdseq_evt_if evt_ch ();

    lcd_nibble_command_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_evt      (evt_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // sequencer state as the LCD sees it
    logic [7:0]  fn_set_cmd  = FN_SET_RST;
    logic [7:0]  disp_cmd    = DISP_CTL_RST;
    logic [7:0]  entry_cmd   = ENTRY_MODE_RST;
    logic [9:0]  short_us    = SHORT_WAIT_RST;
    logic [15:0] long_us     = LONG_WAIT_RST;
    logic [15:0] powerup_us  = POWERUP_WAIT_RST;
    logic [15:0] settle_us   = '0;

    t_strobe due_strobes [$];
    t_strobe fresh_strobes [$];

    int fail_count = 0;
    int n_req      = 0;
    int n_strobes  = 0;
    int rnd_count  = 0;
    int src_idle_pct  = 6;
    int sink_idle_pct = 81;
    longint cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void add_strobe(logic [3:0] nib, logic rs, logic [15:0] wait_us,
                                       logic last);
        t_strobe s;
        s.nib     = nib;
        s.rs      = rs;
        s.wait_us = wait_us;
        s.last    = last;
        fresh_strobes.push_back(s);
    endfunction

    function automatic void add_byte(logic [7:0] b, logic rs, logic last);
        add_strobe(b[7:4], rs, settle_us, 1'b0);
        add_strobe(b[3:0], rs, 16'd0, last);
        settle_us = (b <= LONG_CMD_MAX) ? long_us : {6'd0, short_us};
    endfunction

    function automatic void expand_request(logic rt, logic [7:0] b, logic dat);
        if (rt == REQ_WRITE) begin
            add_byte(b, dat, 1'b1);
        end else begin
            add_strobe(WAKE_NIB, 1'b0, powerup_us, 1'b0);
            add_strobe(WAKE_NIB, 1'b0, WAKE_GAP_US, 1'b0);
            add_strobe(WAKE_NIB, 1'b0, WAKE_GAP_US, 1'b0);
            add_strobe(BUS4_NIB, 1'b0, {6'd0, short_us}, 1'b0);
            settle_us = {6'd0, short_us};
            add_byte(fn_set_cmd, 1'b0, 1'b0);
            add_byte(CURSOR_SHIFT_CMD, 1'b0, 1'b0);
            add_byte(disp_cmd, 1'b0, 1'b0);
            add_byte(entry_cmd, 1'b0, 1'b1);
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_strobe want;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                fresh_strobes.delete();
                expand_request(req_ch.req_type, req_ch.byte_value, req_ch.is_data);
                if (n_req < N_DIR && DIR_ROWS[n_req].typed) begin
                    due_strobes.push_back(DIR_ROWS[n_req].hi);
                    due_strobes.push_back(DIR_ROWS[n_req].lo);
                end else begin
                    foreach (fresh_strobes[k]) due_strobes.push_back(fresh_strobes[k]);
                end
                n_req++;
            end
            if (evt_ch.valid && evt_ch.ready) begin
                if (due_strobes.size() == 0) begin
                    $error("strobe beat with nothing expected: nibble %0h wait %0d",
                           evt_ch.nibble, evt_ch.wait_before_us);
                    fail_count++;
                end else begin
                    want = due_strobes.pop_front();
                    check_field("nibble", want.nib, evt_ch.nibble);
                    check_field("reg_select", want.rs, evt_ch.reg_select);
                    check_field("wait_before_us", want.wait_us, evt_ch.wait_before_us);
                    check_field("last", want.last, evt_ch.last);
                end
                n_strobes <= n_strobes + 1;
            end
        end
    end

    // output side: random stalls plus one long hold-off so the block backs up
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        evt_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                evt_ch.ready <= 1'b0;
            end else if (!hold_done && n_strobes >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                evt_ch.ready <= 1'b0;
            end else begin
                evt_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_req(input logic rt, input logic [7:0] b, input logic dat);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= rt;
        req_ch.byte_value <= b;
        req_ch.is_data    <= dat;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (due_strobes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_FN_SET:     fn_set_cmd = data[7:0];
            CFG_DISP_CTL:   disp_cmd   = data[7:0];
            CFG_ENTRY_MODE: entry_cmd  = data[7:0];
            CFG_SHORT_WAIT: short_us   = data[9:0];
            CFG_LONG_WAIT:  long_us    = data[15:0];
            CFG_PWR_WAIT:   powerup_us = data[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] fn, input logic [15:0] disp,
                                  input logic [15:0] entry, input logic [15:0] shrt,
                                  input logic [15:0] lng, input logic [15:0] pwr);
        write_reg(CFG_FN_SET, fn);
        write_reg(CFG_DISP_CTL, disp);
        write_reg(CFG_ENTRY_MODE, entry);
        write_reg(CFG_SHORT_WAIT, shrt);
        write_reg(CFG_LONG_WAIT, lng);
        write_reg(CFG_PWR_WAIT, pwr);
        write_reg(CFG_SPARE_A, 16'($urandom));
        write_reg(CFG_SPARE_B, 16'($urandom));
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(input int n);
        logic       rt;
        logic [7:0] b;
        logic       dat;
        repeat (n) begin
            case (rnd_count * 3 / RANDOM_ITEMS)
                0: begin
                    src_idle_pct  = 6;
                    sink_idle_pct = 81;
                end
                1: begin
                    src_idle_pct  = 81;
                    sink_idle_pct = 6;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            rt  = ($urandom_range(9) == 0) ? REQ_INIT : REQ_WRITE;
            b   = ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
            dat = 1'($urandom);
            send_req(rt, b, dat);
            rnd_count++;
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = '0;
        cfg_data          = '0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_WRITE;
        req_ch.byte_value = '0;
        req_ch.is_data    = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_ROWS[r]) send_req(DIR_ROWS[r].rt, DIR_ROWS[r].byt, DIR_ROWS[r].dat);
        drain();

        apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        run_random(70);
        drain();

        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(70);
        drain();

        apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom));
        run_random(70);
        drain();

        // init whose function-set and entry bytes take the long settle
        apply_settings(16'($urandom_range(3)), 16'($urandom), 16'($urandom_range(3)),
                       16'd1023, 16'hFFFF, 16'h0000);
        run_random(70);
        drain();

        apply_settings(FN_SET_RST, DISP_CTL_RST, ENTRY_MODE_RST, SHORT_WAIT_RST,
                       LONG_WAIT_RST, POWERUP_WAIT_RST);
        run_random(70);
        drain();

        apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom));
        run_random(RANDOM_ITEMS - 350);
        drain();

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
